// File: src/llh_pkg.sv
`timescale 1ns / 1ps

package llh_pkg;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned TIME_W   = 64;
  localparam int unsigned SIZE_W   = 32;
  localparam int unsigned IDX_W    = 12;
  localparam int unsigned CNT_W    = 64;
  localparam int unsigned BUCKET_W = 6;
  localparam int unsigned HELD_W   = 13;

  typedef enum logic [OP_W-1:0] {
    OP_RECORD      = 2'd0,
    OP_READ_BUCKET = 2'd1,
    OP_READ_SAMPLE = 2'd2
  } op_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [TIME_W-1:0] submit_time;
    logic [TIME_W-1:0] receive_time;
    logic [SIZE_W-1:0] record_size;
    logic [IDX_W-1:0]  read_index;
  } in_item_t;

  typedef struct packed {
    logic [TIME_W-1:0]   latency;
    logic [BUCKET_W-1:0] bucket_number;
    logic [CNT_W-1:0]    events_seen;
    logic [CNT_W-1:0]    bytes_seen;
    logic [HELD_W-1:0]   samples_held;
    logic [CNT_W-1:0]    read_value;
    logic                read_valid;
  } out_item_t;

endpackage

// File: src/llh_if.sv
`timescale 1ns / 1ps

interface llh_in_if;
  logic               valid;
  logic               ready;
  llh_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface llh_out_if;
  logic               valid;
  logic               ready;
  llh_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/latency_log2_histogram.sv
`timescale 1ns / 1ps

// channel   dir  handshake     payload
// in_ch     in   valid/ready   llh_pkg::in_item_t  (op, timestamps, size, index)
// out_ch    out  valid/ready   llh_pkg::out_item_t (latency, bucket, counters, read)
//
// one beat in and one beat out per cycle while the output is not stalled
// stages: input reg, subtract and sample store, log2 bucket and count read,
// count update and output reg; bucket count read-modify-write forwards one stage
// synchronous active-low reset clears counters, fill level and bucket valid bits
// a stalled output holds every stage, bubbles included

module latency_log2_histogram #(
  parameter int SAMPLE_DEPTH = 4096,
  parameter int BUCKET_COUNT = 64
) (
  input logic       clk,
  input logic       rst_n,
  llh_in_if.sink    in_ch,
  llh_out_if.source out_ch
);
  import llh_pkg::*;

  localparam int AW  = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
  localparam int FW  = $clog2(SAMPLE_DEPTH + 1);
  localparam int BAW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
  localparam int CW  = (FW > IDX_W) ? FW : IDX_W;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [TIME_W-1:0] lat;
    logic [IDX_W-1:0]  idx;
    logic [CNT_W-1:0]  events;
    logic [CNT_W-1:0]  bytes;
    logic [HELD_W-1:0] held;
    logic              samp_ok;
  } b_stage_t;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [TIME_W-1:0]   lat;
    logic [BUCKET_W-1:0] bucket;
    logic [BAW-1:0]      addr;
    logic [CNT_W-1:0]    events;
    logic [CNT_W-1:0]    bytes;
    logic [HELD_W-1:0]   held;
    logic                samp_ok;
    logic [TIME_W-1:0]   samp;
    logic                bread_ok;
    logic                fwd;
    logic [CNT_W-1:0]    fwd_val;
  } c_stage_t;

  logic adv;

  logic     a_valid_r;
  in_item_t a_r;
  logic     b_valid_r;
  b_stage_t b_r;
  logic     c_valid_r;
  c_stage_t c_r;
  logic      out_valid_r;
  out_item_t out_r;

  logic [CNT_W-1:0] events_r, events_nxt;
  logic [CNT_W-1:0] bytes_r, bytes_nxt;
  logic [FW-1:0]    fill_r, fill_nxt;

  logic [TIME_W-1:0] samp_mem [SAMPLE_DEPTH];
  logic [TIME_W-1:0] samp_rd_r;
  logic [CNT_W-1:0]  bkt_mem [BUCKET_COUNT];
  logic [CNT_W-1:0]  bkt_rd_r;
  logic [BUCKET_COUNT-1:0] bkt_vld_r;
  logic              bkt_vld_rd_r;

  logic              a_rec, a_room, a_samp_ok, samp_wr;
  logic [TIME_W-1:0] a_lat;
  b_stage_t          b_nxt;

  logic                b_rec, b_bread_ok, b_fwd;
  logic [BUCKET_W-1:0] b_log, b_bucket;
  logic [BAW-1:0]      b_addr;
  c_stage_t            c_nxt;

  logic             c_wr;
  logic [CNT_W-1:0] c_base, c_new;
  out_item_t        out_nxt;

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r <= in_ch.valid;
    end
    if (adv) begin
      a_r <= in_ch.data;
    end
  end

  // stage a: latency, counters, sample store
  always_comb begin
    a_rec      = a_valid_r && (a_r.op == OP_RECORD);
    a_lat      = a_r.receive_time - a_r.submit_time;
    a_room     = fill_r < FW'(SAMPLE_DEPTH);
    events_nxt = a_rec ? events_r + CNT_W'(1) : events_r;
    bytes_nxt  = a_rec ? bytes_r + CNT_W'(a_r.record_size) : bytes_r;
    fill_nxt   = (a_rec && a_room) ? fill_r + FW'(1) : fill_r;
    a_samp_ok  = (a_r.op == OP_READ_SAMPLE) && (CW'(a_r.read_index) < CW'(fill_r));
    samp_wr    = adv && a_rec && a_room;

    b_nxt.op      = a_r.op;
    b_nxt.lat     = a_lat;
    b_nxt.idx     = a_r.read_index;
    b_nxt.events  = events_nxt;
    b_nxt.bytes   = bytes_nxt;
    b_nxt.held    = HELD_W'(fill_nxt);
    b_nxt.samp_ok = a_samp_ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      events_r <= '0;
      bytes_r  <= '0;
      fill_r   <= '0;
    end else if (adv) begin
      events_r <= events_nxt;
      bytes_r  <= bytes_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (samp_wr) begin
      samp_mem[AW'(fill_r)] <= a_lat;
    end
    if (adv) begin
      samp_rd_r <= samp_mem[AW'(a_r.read_index)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (adv) begin
      b_valid_r <= a_valid_r;
    end
    if (adv) begin
      b_r <= b_nxt;
    end
  end

  // stage b: log2 bucket, count read with forwarding from stage c
  always_comb begin
    b_log = '0;
    for (int i = 1; i < TIME_W; i++) begin
      if (b_r.lat[i]) begin
        b_log = BUCKET_W'(i);
      end
    end
    b_bucket   = (b_log > BUCKET_W'(BUCKET_COUNT - 1)) ? BUCKET_W'(BUCKET_COUNT - 1) : b_log;
    b_rec      = b_r.op == OP_RECORD;
    b_bread_ok = (b_r.op == OP_READ_BUCKET) && (b_r.idx < IDX_W'(BUCKET_COUNT));
    b_addr     = b_rec ? BAW'(b_bucket) : BAW'(b_r.idx);
    b_fwd      = c_wr && (c_r.addr == b_addr);

    c_nxt.op       = b_r.op;
    c_nxt.lat      = b_rec ? b_r.lat : '0;
    c_nxt.bucket   = b_rec ? b_bucket : '0;
    c_nxt.addr     = b_addr;
    c_nxt.events   = b_r.events;
    c_nxt.bytes    = b_r.bytes;
    c_nxt.held     = b_r.held;
    c_nxt.samp_ok  = b_r.samp_ok;
    c_nxt.samp     = samp_rd_r;
    c_nxt.bread_ok = b_bread_ok;
    c_nxt.fwd      = b_fwd;
    c_nxt.fwd_val  = c_new;
  end

  always_ff @(posedge clk) begin
    if (c_wr) begin
      bkt_mem[c_r.addr] <= c_new;
    end
    if (adv) begin
      bkt_rd_r     <= bkt_mem[b_addr];
      bkt_vld_rd_r <= bkt_vld_r[b_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bkt_vld_r <= '0;
    end else if (c_wr) begin
      bkt_vld_r[c_r.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else if (adv) begin
      c_valid_r <= b_valid_r;
    end
    if (adv) begin
      c_r <= c_nxt;
    end
  end

  // stage c: count update and result assembly
  always_comb begin
    c_wr   = adv && c_valid_r && (c_r.op == OP_RECORD);
    c_base = c_r.fwd ? c_r.fwd_val : (bkt_vld_rd_r ? bkt_rd_r : '0);
    c_new  = c_base + CNT_W'(1);

    out_nxt.latency       = c_r.lat;
    out_nxt.bucket_number = c_r.bucket;
    out_nxt.events_seen   = c_r.events;
    out_nxt.bytes_seen    = c_r.bytes;
    out_nxt.samples_held  = c_r.held;
    out_nxt.read_value    = '0;
    out_nxt.read_valid    = 1'b0;
    case (c_r.op)
      OP_READ_BUCKET: begin
        out_nxt.read_value = c_r.bread_ok ? c_base : '0;
        out_nxt.read_valid = c_r.bread_ok;
      end
      OP_READ_SAMPLE: begin
        out_nxt.read_value = c_r.samp_ok ? c_r.samp : '0;
        out_nxt.read_valid = c_r.samp_ok;
      end
      default: begin
        out_nxt.read_value = '0;
        out_nxt.read_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= c_valid_r;
    end
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(SAMPLE_DEPTH))
    else $error("sample fill beyond store depth");

  a_events_step: assert property (@(posedge clk) disable iff (!rst_n)
    (events_r == $past(events_r)) || (events_r == $past(events_r) + CNT_W'(1)))
    else $error("event counter jumped");

  a_read_no_record: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.read_valid) |-> (out_r.latency == '0 && out_r.bucket_number == '0))
    else $error("read result carries record fields");

  a_bucket_lat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.bucket_number != '0) |-> (out_r.latency[TIME_W-1:1] != '0))
    else $error("nonzero bucket for latency below two");

endmodule
